[rtl/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg: shared definitions for the Michael MIC engine
// Operation codes, field widths and the control bundle that the sequencer
// hands to the shared round unit.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam int WORD_W     = 32;
	localparam int KEY_W      = 64;
	localparam int ADDR_W     = 48;
	localparam int BYTE_W     = 8;
	localparam int PART_W     = 24;
	localparam int CFG_ADDR_W = 4;
	localparam int WQ_DEPTH   = 4;

	localparam logic [BYTE_W-1:0] MARK_BYTE = 8'h5a;

	// Register indexes of the configuration port.
	localparam logic REG_MIC_KEY = 1'b0;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_BYTE   = 2'd1,
		OP_FINISH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Round selector of the Michael block function.
	typedef enum logic [1:0] {
		RND_ROT17 = 2'd0,
		RND_SWAP  = 2'd1,
		RND_ROT3  = 2'd2,
		RND_ROT30 = 2'd3
	} rnd_t;

	typedef struct packed {
		rnd_t step;
		logic load_word;
	} round_ctl_t;

endpackage

[rtl/mme_round.sv]
// ----------------------------------------------------------------------------
// mme_round: one round of the Michael block function
// Mixes the message word into the left word on the first round, then applies
// one xor-rotate (or byte swap) and one 32-bit add.
// ----------------------------------------------------------------------------
module mme_round (
	input  mme_pkg::round_ctl_t          ctl,
	input  logic [mme_pkg::WORD_W-1:0]   left_in,
	input  logic [mme_pkg::WORD_W-1:0]   right_in,
	input  logic [mme_pkg::WORD_W-1:0]   word_in,
	output logic [mme_pkg::WORD_W-1:0]   left_out,
	output logic [mme_pkg::WORD_W-1:0]   right_out
);

	logic [mme_pkg::WORD_W-1:0] l0;
	logic [mme_pkg::WORD_W-1:0] mix;

	always_comb begin
		l0 = ctl.load_word ? (left_in ^ word_in) : left_in;
		case (ctl.step)
			mme_pkg::RND_ROT17: mix = {l0[14:0], l0[31:15]};
			mme_pkg::RND_SWAP:  mix = {l0[23:16], l0[31:24], l0[7:0], l0[15:8]};
			mme_pkg::RND_ROT3:  mix = {l0[28:0], l0[31:29]};
			mme_pkg::RND_ROT30: mix = {l0[1:0], l0[31:2]};
			default:            mix = l0;
		endcase
		right_out = right_in ^ mix;
		left_out  = l0 + right_out;
	end

endmodule

[rtl/mme_cfg.sv]
// ----------------------------------------------------------------------------
// mme_cfg: configuration register file
// Holds the 64-bit Michael key behind an APB-style port with zero wait states.
// ----------------------------------------------------------------------------
module mme_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mme_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [mme_pkg::KEY_W-1:0]        pwdata,
	output logic [mme_pkg::KEY_W-1:0]        prdata,
	output logic                             pready,
	output logic [mme_pkg::KEY_W-1:0]        key
);

	logic [mme_pkg::KEY_W-1:0] key_q;
	logic                      reg_idx;

	// Registers sit 8 bytes apart, so bit 3 selects the register.
	assign reg_idx = paddr[3];
	assign pready  = 1'b1;
	assign key     = key_q;
	assign prdata  = (reg_idx == mme_pkg::REG_MIC_KEY) ? key_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& (reg_idx == mme_pkg::REG_MIC_KEY)) begin
			key_q <= pwdata;
		end
	end

endmodule

[rtl/michael_mic_engine.sv]
// ----------------------------------------------------------------------------
// michael_mic_engine: 802.11 TKIP Michael message integrity code
// Iterative engine: one shared round unit runs the block function one round
// per cycle under a small sequencer.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid, in_stall) carries one transaction per
// item: op selects start, payload byte or finish. A start transaction seeds
// the chaining words from the key register and absorbs the 16-byte
// pseudo-header built from dest_addr, src_addr and prio. Each payload
// transaction adds one byte; every fourth byte completes a word. A finish
// transaction appends the 0x5a marker, pads, absorbs a zero word and sends
// the 64-bit code as one transaction on the output channel (out_valid,
// out_stall), left word in bits 31:0.
// Timing. Each absorbed word takes four rounds of the shared round unit,
// one round per cycle. The block is busy (in_stall high) after a start while
// it absorbs the four header words, after a byte that completes a word while
// it absorbs that word, and after a finish until its code is in the output
// register. Other bytes go at one per cycle while the engine is idle.
// The finished code sits in an output register; a new item is taken while it
// waits. If the receiver stalls and a second code is ready, the engine holds
// it and keeps in_stall high until the output register is free.
// Reset clears the key, chaining words and byte gatherer; the user must write
// the key over the APB-style port while the engine is idle (not enforced).
// ----------------------------------------------------------------------------
module michael_mic_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mme_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [mme_pkg::KEY_W-1:0]          pwdata,
	output logic [mme_pkg::KEY_W-1:0]          prdata,
	output logic                               pready,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         op,
	input  logic [mme_pkg::ADDR_W-1:0]         dest_addr,
	input  logic [mme_pkg::ADDR_W-1:0]         src_addr,
	input  logic [mme_pkg::BYTE_W-1:0]         prio,
	input  logic [mme_pkg::BYTE_W-1:0]         data_byte,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [mme_pkg::KEY_W-1:0]          mic
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t                          state_q;
	logic [mme_pkg::KEY_W-1:0]       key;
	logic [mme_pkg::WORD_W-1:0]      left_q;
	logic [mme_pkg::WORD_W-1:0]      right_q;
	logic [mme_pkg::PART_W-1:0]      part_q;
	logic [1:0]                      pcnt_q;
	logic [mme_pkg::WORD_W-1:0]      wq_q [mme_pkg::WQ_DEPTH];
	logic [1:0]                      wleft_q;
	mme_pkg::rnd_t                   step_q;
	logic                            emit_q;
	logic                            out_valid_q;
	logic [mme_pkg::KEY_W-1:0]       mic_q;

	mme_pkg::round_ctl_t             rctl;
	logic [mme_pkg::WORD_W-1:0]      rnd_l;
	logic [mme_pkg::WORD_W-1:0]      rnd_r;
	logic [mme_pkg::PART_W-1:0]      part_next;
	logic [mme_pkg::WORD_W-1:0]      last_word;
	logic                            in_acc;
	logic                            slot_free;

	mme_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key     (key)
	);

	// The message word is mixed in only on the first round of each word.
	assign rctl.step      = step_q;
	assign rctl.load_word = (step_q == mme_pkg::RND_ROT17);

	mme_round u_round (
		.ctl       (rctl),
		.left_in   (left_q),
		.right_in  (right_q),
		.word_in   (wq_q[0]),
		.left_out  (rnd_l),
		.right_out (rnd_r)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign mic       = mic_q;
	assign slot_free = !out_valid_q || !out_stall;

	// Byte gatherer: insert the new byte at the next free lane, and build the
	// closing word with the marker byte after the gathered bytes.
	always_comb begin
		part_next = part_q;
		last_word = {8'h00, part_q};
		case (pcnt_q)
			2'd0: begin
				part_next[7:0]  = data_byte;
				last_word[7:0]  = mme_pkg::MARK_BYTE;
			end
			2'd1: begin
				part_next[15:8] = data_byte;
				last_word[15:8] = mme_pkg::MARK_BYTE;
			end
			2'd2: begin
				part_next[23:16] = data_byte;
				last_word[23:16] = mme_pkg::MARK_BYTE;
			end
			default: begin
				last_word[31:24] = mme_pkg::MARK_BYTE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			left_q      <= '0;
			right_q     <= '0;
			part_q      <= '0;
			pcnt_q      <= '0;
			wleft_q     <= '0;
			step_q      <= mme_pkg::RND_ROT17;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
			mic_q       <= '0;
			for (int i = 0; i < mme_pkg::WQ_DEPTH; i++) begin
				wq_q[i] <= '0;
			end
		end else begin
			// A held code moves into the output register as soon as it is free;
			// otherwise the register empties when its code is taken.
			if (state_q == ST_HOLD && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (mme_pkg::op_t'(op))
							mme_pkg::OP_START: begin
								left_q  <= key[31:0];
								right_q <= key[63:32];
								part_q  <= '0;
								pcnt_q  <= '0;
								wq_q[0] <= dest_addr[31:0];
								wq_q[1] <= {src_addr[15:0], dest_addr[47:32]};
								wq_q[2] <= src_addr[47:16];
								wq_q[3] <= {24'h000000, prio};
								wleft_q <= 2'd3;
								step_q  <= mme_pkg::RND_ROT17;
								emit_q  <= 1'b0;
								state_q <= ST_RUN;
							end
							mme_pkg::OP_BYTE: begin
								if (pcnt_q == 2'd3) begin
									wq_q[0] <= {data_byte, part_q};
									wleft_q <= 2'd0;
									part_q  <= '0;
									pcnt_q  <= '0;
									step_q  <= mme_pkg::RND_ROT17;
									emit_q  <= 1'b0;
									state_q <= ST_RUN;
								end else begin
									part_q <= part_next;
									pcnt_q <= pcnt_q + 2'd1;
								end
							end
							mme_pkg::OP_FINISH: begin
								wq_q[0] <= last_word;
								wq_q[1] <= '0;
								wleft_q <= 2'd1;
								part_q  <= '0;
								pcnt_q  <= '0;
								step_q  <= mme_pkg::RND_ROT17;
								emit_q  <= 1'b1;
								state_q <= ST_RUN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					left_q  <= rnd_l;
					right_q <= rnd_r;
					step_q  <= mme_pkg::rnd_t'(step_q + 2'd1);
					if (step_q == mme_pkg::RND_ROT30) begin
						if (wleft_q == 2'd0) begin
							state_q <= emit_q ? ST_HOLD : ST_IDLE;
						end else begin
							for (int i = 0; i < mme_pkg::WQ_DEPTH - 1; i++) begin
								wq_q[i] <= wq_q[i+1];
							end
							wleft_q <= wleft_q - 2'd1;
						end
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						mic_q   <= {right_q, left_q};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Michael MIC engine
// Drives frames (start with pseudo-header, payload bytes, finish) through the
// input channel with bursty timing, stalls the output channel on its own
// pattern, and compares every code with a cycle-free model of the engine kept
// in a small scoreboard class. The key is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Generous ceiling on the run length, in clock cycles.
	localparam int CYCLE_LIMIT = 400000;
	// Quiet cycles before a key write and at the end, so that a finish has produced
	// its code and a word completion no longer keeps the engine busy.
	localparam int SETTLE_CYCLES = 24;
	// The only register sits at byte address zero (64-bit registers, 8-byte spacing).
	localparam logic [mme_pkg::CFG_ADDR_W-1:0] KEY_ADDR =
		mme_pkg::CFG_ADDR_W'(8 * int'(mme_pkg::REG_MIC_KEY));

	typedef struct {
		mme_pkg::op_t               kind;
		logic [mme_pkg::ADDR_W-1:0] dest;
		logic [mme_pkg::ADDR_W-1:0] src;
		logic [mme_pkg::BYTE_W-1:0] pri;
		logic [mme_pkg::BYTE_W-1:0] payload;
	} frame_item_t;

	typedef enum int {
		STALL_NONE,
		STALL_SPARSE,
		STALL_LONG
	} stall_mode_t;

	// Cycle-free model of the engine: chaining words, byte gatherer and key,
	// plus the queue of codes that are still to come out.
	class mic_scoreboard;
		logic [mme_pkg::KEY_W-1:0]  key;
		logic [mme_pkg::WORD_W-1:0] left_w;
		logic [mme_pkg::WORD_W-1:0] right_w;
		logic [mme_pkg::PART_W-1:0] gathered;
		logic [1:0]                 gathered_cnt;
		logic [mme_pkg::KEY_W-1:0]  codes_due[$];
		int                         errors;
		int                         frames;
		int                         codes_seen;

		function new();
			key          = '0;
			left_w       = '0;
			right_w      = '0;
			gathered     = '0;
			gathered_cnt = '0;
			errors       = 0;
			frames       = 0;
			codes_seen   = 0;
		endfunction

		function void set_key(logic [mme_pkg::KEY_W-1:0] value);
			key = value;
		endfunction

		function logic [mme_pkg::WORD_W-1:0] rotl(logic [mme_pkg::WORD_W-1:0] v, int n);
			return (v << n) | (v >> (mme_pkg::WORD_W - n));
		endfunction

		// One run of the Michael block function over a 32-bit word.
		function void mix_word(logic [mme_pkg::WORD_W-1:0] w);
			logic [mme_pkg::WORD_W-1:0] l;
			logic [mme_pkg::WORD_W-1:0] r;
			l = left_w ^ w;
			r = right_w;
			r = r ^ rotl(l, 17);
			l = l + r;
			r = r ^ {l[23:16], l[31:24], l[7:0], l[15:8]};
			l = l + r;
			r = r ^ rotl(l, 3);
			l = l + r;
			r = r ^ rotl(l, 30);
			l = l + r;
			left_w  = l;
			right_w = r;
		endfunction

		function void note_input(frame_item_t it);
			logic [mme_pkg::WORD_W-1:0] w;
			case (it.kind)
				mme_pkg::OP_START: begin
					frames++;
					left_w       = key[31:0];
					right_w      = key[63:32];
					gathered     = '0;
					gathered_cnt = '0;
					mix_word(it.dest[31:0]);
					mix_word({it.src[15:0], it.dest[47:32]});
					mix_word(it.src[47:16]);
					mix_word({24'd0, it.pri});
				end
				mme_pkg::OP_BYTE: begin
					if (gathered_cnt == 2'd3) begin
						mix_word({it.payload, gathered});
						gathered     = '0;
						gathered_cnt = '0;
					end else begin
						gathered[8*gathered_cnt +: 8] = it.payload;
						gathered_cnt = gathered_cnt + 2'd1;
					end
				end
				mme_pkg::OP_FINISH: begin
					w = {8'd0, gathered};
					w[8*gathered_cnt +: 8] = mme_pkg::MARK_BYTE;
					mix_word(w);
					mix_word('0);
					gathered     = '0;
					gathered_cnt = '0;
					codes_due.push_back({right_w, left_w});
				end
				default: begin
				end
			endcase
		endfunction

		function void check_mic(logic [mme_pkg::KEY_W-1:0] got);
			logic [mme_pkg::KEY_W-1:0] want;
			codes_seen++;
			if (codes_due.size() == 0) begin
				$error("mic: no code expected, actual %h", got);
				errors++;
			end else begin
				want = codes_due.pop_front();
				if (got !== want) begin
					$error("mic: expected %h, actual %h", want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return codes_due.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [mme_pkg::CFG_ADDR_W-1:0] paddr;
	logic [mme_pkg::KEY_W-1:0]      pwdata;
	logic [mme_pkg::KEY_W-1:0]      prdata;
	logic                           pready;
	logic                           in_valid;
	logic                           in_stall;
	logic [1:0]                     op;
	logic [mme_pkg::ADDR_W-1:0]     dest_addr;
	logic [mme_pkg::ADDR_W-1:0]     src_addr;
	logic [mme_pkg::BYTE_W-1:0]     prio;
	logic [mme_pkg::BYTE_W-1:0]     data_byte;
	logic                           out_valid;
	logic                           out_stall;
	logic [mme_pkg::KEY_W-1:0]      mic;

	mic_scoreboard sb = new();

	// Transactions left in the current sender burst, and the count of items
	// that the engine acts on (unused op codes are not counted).
	int burst_left;
	int items_sent;
	int key_writes;

	michael_mic_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.dest_addr (dest_addr),
		.src_addr  (src_addr),
		.prio      (prio),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.mic       (mic)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Output side. Codes are checked at the edge where they are taken, and the
	// stall line follows a pattern of its own: spells with no stall at all,
	// spells of scattered stalls, and spells of long stalls. Reading at the edge
	// sees the values from before it, so the check never races the engine's own
	// register updates.
	initial begin
		stall_mode_t mode;
		int          mode_left;
		int          run_left;
		logic        run_level;
		out_stall = 1'b0;
		mode_left = 0;
		run_left  = 0;
		run_level = 1'b0;
		mode      = STALL_NONE;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_mic(mic);
			if (mode_left == 0) begin
				mode      = stall_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			case (mode)
				STALL_NONE: begin
					out_stall <= 1'b0;
				end
				STALL_SPARSE: begin
					out_stall <= ($urandom_range(0, 2) == 0);
				end
				default: begin
					if (run_left == 0) begin
						run_left  = $urandom_range(1, 20);
						run_level = ~run_level;
					end
					run_left--;
					out_stall <= run_level;
				end
			endcase
		end
	end

	function automatic logic [mme_pkg::ADDR_W-1:0] rand_addr();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return {16'($urandom), 32'($urandom)};
		endcase
	endfunction

	function automatic frame_item_t make_item(mme_pkg::op_t kind,
			logic [mme_pkg::ADDR_W-1:0] dest, logic [mme_pkg::ADDR_W-1:0] src,
			logic [mme_pkg::BYTE_W-1:0] pri, logic [mme_pkg::BYTE_W-1:0] payload);
		frame_item_t it;
		it.kind    = kind;
		it.dest    = dest;
		it.src     = src;
		it.pri     = pri;
		it.payload = payload;
		return it;
	endfunction

	// Every field carries random content whatever the op, so that the engine
	// is also seen to ignore the fields that an op does not use.
	function automatic frame_item_t rand_item(mme_pkg::op_t kind);
		return make_item(kind, rand_addr(), rand_addr(), 8'($urandom), 8'($urandom));
	endfunction

	// Present one transaction and hold it until the engine takes it. Valid is
	// raised only here, and lowered at the end of a burst or by settle(); at the
	// end of a burst the task waits out a random gap before the next item.
	task automatic send_item(frame_item_t it);
		in_valid  <= 1'b1;
		op        <= it.kind;
		dest_addr <= it.dest;
		src_addr  <= it.src;
		prio      <= it.pri;
		data_byte <= it.payload;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(it);
		if (it.kind != mme_pkg::OP_NONE)
			items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			// Mostly short bursts, now and then a long stretch with no gap.
			if ($urandom_range(0, 5) == 0)
				burst_left = $urandom_range(30, 60);
			else
				burst_left = $urandom_range(1, 12);
		end
	endtask

	// Drop valid and wait until every code has come out and the engine has
	// had time to finish any word it is still mixing.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Key write: a setup phase, then an access phase that completes on pready.
	task automatic write_key(logic [mme_pkg::KEY_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= KEY_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_key(value);
		key_writes++;
	endtask

	// Payload lengths: mostly short frames, some medium, a few long ones.
	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(0, 12);
		else if (r < 95)
			return $urandom_range(13, 40);
		else
			return $urandom_range(41, 80);
	endfunction

	// One random sequence. Most are well-formed frames with random content;
	// the rest are unused op codes, frames cut short by a new start, or bytes
	// and a finish with no start in front of them.
	task automatic random_sequence();
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			send_item(rand_item(mme_pkg::OP_START));
			len = pick_length();
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 29) == 0)
					send_item(rand_item(mme_pkg::OP_NONE));
				send_item(rand_item(mme_pkg::OP_BYTE));
			end
			send_item(rand_item(mme_pkg::OP_FINISH));
		end else if (r < 91) begin
			repeat ($urandom_range(1, 3)) send_item(rand_item(mme_pkg::OP_NONE));
		end else if (r < 96) begin
			send_item(rand_item(mme_pkg::OP_START));
			repeat ($urandom_range(0, 6)) send_item(rand_item(mme_pkg::OP_BYTE));
		end else begin
			repeat ($urandom_range(0, 6)) send_item(rand_item(mme_pkg::OP_BYTE));
			send_item(rand_item(mme_pkg::OP_FINISH));
		end
	endtask

	initial begin
		logic [mme_pkg::KEY_W-1:0] phase_keys[6];
		int                        goal;

		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		op        = mme_pkg::OP_NONE;
		dest_addr = '0;
		src_addr  = '0;
		prio      = '0;
		data_byte = '0;
		burst_left = 1;
		items_sent = 0;
		key_writes = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset the key and chaining words are zero: an unused
		// op, a finish with no start, bytes and a finish with no start, then a start
		// with an all-zero header followed directly by a finish (empty payload).
		send_item(rand_item(mme_pkg::OP_NONE));
		send_item(rand_item(mme_pkg::OP_FINISH));
		send_item(make_item(mme_pkg::OP_BYTE, '1, '1, 8'hff, 8'hff));
		send_item(make_item(mme_pkg::OP_BYTE, '0, '0, 8'h00, 8'h00));
		send_item(rand_item(mme_pkg::OP_FINISH));
		send_item(make_item(mme_pkg::OP_START, '0, '0, 8'h00, 8'h00));
		send_item(rand_item(mme_pkg::OP_FINISH));
		settle();

		// All-ones key and header, byte extremes, an unused op inside the
		// payload, and finishes with one, three and no bytes left over.
		write_key('1);
		send_item(make_item(mme_pkg::OP_START, '1, '1, 8'hff, 8'h00));
		send_item(make_item(mme_pkg::OP_BYTE, '0, '0, 8'h00, 8'h00));
		send_item(make_item(mme_pkg::OP_BYTE, '0, '0, 8'h00, 8'hff));
		send_item(rand_item(mme_pkg::OP_NONE));
		send_item(make_item(mme_pkg::OP_BYTE, '0, '0, 8'h00, 8'h5a));
		send_item(make_item(mme_pkg::OP_BYTE, '0, '0, 8'h00, 8'ha5));
		send_item(make_item(mme_pkg::OP_BYTE, '0, '0, 8'h00, 8'h80));
		send_item(rand_item(mme_pkg::OP_FINISH));
		send_item(make_item(mme_pkg::OP_START, 48'haaaa_5555_aaaa, 48'h5555_aaaa_5555,
			8'h80, 8'h00));
		send_item(make_item(mme_pkg::OP_BYTE, '0, '0, 8'h00, 8'h01));
		send_item(make_item(mme_pkg::OP_BYTE, '0, '0, 8'h00, 8'h02));
		send_item(make_item(mme_pkg::OP_BYTE, '0, '0, 8'h00, 8'h03));
		send_item(rand_item(mme_pkg::OP_FINISH));
		// A start in the middle of a frame throws the partial frame away.
		send_item(rand_item(mme_pkg::OP_START));
		send_item(rand_item(mme_pkg::OP_BYTE));
		send_item(rand_item(mme_pkg::OP_START));
		repeat (4) send_item(rand_item(mme_pkg::OP_BYTE));
		send_item(rand_item(mme_pkg::OP_FINISH));
		settle();

		// Random phases, each under its own key. A phase may stop in the middle
		// of a frame, so the next phase goes on with words seeded from the old
		// key, which checks that the key only counts at a start.
		phase_keys[0] = '0;
		phase_keys[1] = {$urandom, $urandom};
		phase_keys[2] = 64'h5555_5555_5555_5555;
		phase_keys[3] = 64'haaaa_aaaa_aaaa_aaaa;
		phase_keys[4] = {$urandom, $urandom};
		phase_keys[5] = '1;
		foreach (phase_keys[k]) begin
			write_key(phase_keys[k]);
			goal = items_sent + 80;
			while (items_sent < goal)
				random_sequence();
			settle();
		end

		$display("summary: %0d items in %0d frames, %0d codes checked, %0d key writes",
			items_sent, sb.frames, sb.codes_seen, key_writes);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
